>>> hdl/udp_header_checksum_builder_core_defines.svh
// assertion macros shared by the udp checksum builder modules
`ifndef UDP_HEADER_CHECKSUM_BUILDER_CORE_DEFINES_SVH
`define UDP_HEADER_CHECKSUM_BUILDER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, quiet while reset is asserted
`define UDPCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds across reset
`define UDPCS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UDPCS_ASSERT(label, prop, msg)
`define UDPCS_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> hdl/udpcs_pkg.sv
// shared types and constants of the udp header and checksum builder
package udpcs_pkg;

  // request kinds
  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_LOCAL_IP   = 1'b0;
  localparam logic REG_GATEWAY_IP = 1'b1;

  // protocol constants
  localparam logic [15:0] UDP_PROTOCOL  = 16'd17;
  localparam logic [15:0] DNS_PORT      = 16'd53;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  // header word positions
  localparam logic [1:0] IDX_SRC_PORT = 2'd0;
  localparam logic [1:0] IDX_DST_PORT = 2'd1;
  localparam logic [1:0] IDX_LENGTH   = 2'd2;
  localparam logic [1:0] IDX_CHECKSUM = 2'd3;

  // one input request
  typedef struct packed {
    logic        action;
    logic [31:0] dest_ip;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic        dns_mode;
    logic [15:0] payload_len;
    logic [15:0] data_word;
    logic        last;
  } in_item_t;

  // the four header words handed to the output buffer
  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] length;
    logic [15:0] checksum;
  } hdr_words_t;

endpackage

>>> hdl/udpcs_if.sv
// request and result channel interfaces of the udp header and checksum builder

// input channel: header and payload requests
interface udpcs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] dest_ip;
  logic [15:0] src_port;
  logic [15:0] dest_port;
  logic        dns_mode;
  logic [15:0] payload_len;
  logic [15:0] data_word;
  logic        last;

  modport source (
    output valid, action, dest_ip, src_port, dest_port, dns_mode,
           payload_len, data_word, last,
    input  ready
  );
  modport sink (
    input  valid, action, dest_ip, src_port, dest_port, dns_mode,
           payload_len, data_word, last,
    output ready
  );
endinterface

// result channel: header words
interface udpcs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (
    output valid, header_word, word_index, last_word,
    input  ready
  );
  modport sink (
    input  valid, header_word, word_index, last_word,
    output ready
  );
endinterface

>>> hdl/udp_header_checksum_builder_core.sv
// UDP header and checksum builder: takes one request per clock, header or payload word.
// A header request seeds the ones' complement checksum with the pseudo-header and the
// UDP header (port 53 and the gateway address in DNS mode); each payload request adds one
// 16-bit word with end-around carry. A request flagged last yields four result words
// (source port, destination port, length, checksum) on four consecutive output
// handshakes, once it has passed the input register and been loaded into the output
// buffer. Throughput is one request per cycle; it is bounded only by the four-word output
// buffer: a final request that comes while a header is still draining stalls the input
// until it has drained. local_ip sits at byte address 0 and gateway_ip at address 4.
module udp_header_checksum_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  udpcs_in_if.sink    in_chan,
  udpcs_out_if.source out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]           local_ip_r;
  logic [31:0]           gateway_ip_r;
  logic                  cfg_wr;
  logic                  hand_valid;
  logic                  hand_ready;
  udpcs_pkg::hdr_words_t hand_words;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r   <= '0;
      gateway_ip_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        udpcs_pkg::REG_LOCAL_IP:   local_ip_r   <= pwdata;
        udpcs_pkg::REG_GATEWAY_IP: gateway_ip_r <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  assign prdata = (paddr[2] == udpcs_pkg::REG_GATEWAY_IP) ? gateway_ip_r : local_ip_r;

  // checksum accumulator
  udpcs_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .local_ip   (local_ip_r),
    .gateway_ip (gateway_ip_r),
    .hand_valid (hand_valid),
    .hand_words (hand_words),
    .hand_ready (hand_ready)
  );

  // header word output
  udpcs_hdr_out u_hdr_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .hand_valid (hand_valid),
    .hand_words (hand_words),
    .hand_ready (hand_ready),
    .out_chan   (out_chan)
  );

endmodule

>>> hdl/udpcs_accum.sv
// input register and ones' complement checksum accumulator
`include "udp_header_checksum_builder_core_defines.svh"

module udpcs_accum (
  input  logic                  clk,
  input  logic                  rst_n,
  udpcs_in_if.sink              in_chan,
  input  logic [31:0]           local_ip,
  input  logic [31:0]           gateway_ip,
  output logic                  hand_valid,
  output udpcs_pkg::hdr_words_t hand_words,
  input  logic                  hand_ready
);

  udpcs_pkg::in_item_t stage_r;
  logic                stage_valid_r;
  logic                stage_fire;
  logic                in_fire;

  logic [15:0] running_sum_r, running_sum_nxt;
  logic [15:0] held_src_port_r, held_src_port_nxt;
  logic [15:0] held_dest_port_r, held_dest_port_nxt;
  logic [15:0] held_udp_length_r, held_udp_length_nxt;

  logic [31:0] dst_ip;
  logic [19:0] seed_wide;
  logic [16:0] seed_fold;
  logic [15:0] seed_sum;
  logic [16:0] word_sum;
  logic [15:0] word_res;

  // the staged request moves on unless it is final and the output buffer is busy
  assign stage_fire    = stage_valid_r && (!stage_r.last || hand_ready);
  assign in_chan.ready = !stage_valid_r || stage_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      stage_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r.action      <= in_chan.action;
      stage_r.dest_ip     <= in_chan.dest_ip;
      stage_r.src_port    <= in_chan.src_port;
      stage_r.dest_port   <= in_chan.dest_port;
      stage_r.dns_mode    <= in_chan.dns_mode;
      stage_r.payload_len <= in_chan.payload_len;
      stage_r.data_word   <= in_chan.data_word;
      stage_r.last        <= in_chan.last;
    end
  end

  // pseudo-header and header seed: wide sum, then two end-around folds
  assign dst_ip    = stage_r.dns_mode ? gateway_ip : stage_r.dest_ip;
  assign seed_wide = 20'(local_ip[31:16]) + 20'(local_ip[15:0])
                   + 20'(dst_ip[31:16]) + 20'(dst_ip[15:0])
                   + 20'(udpcs_pkg::UDP_PROTOCOL)
                   + 20'(held_udp_length_nxt) + 20'(held_udp_length_nxt)
                   + 20'(held_src_port_nxt) + 20'(held_dest_port_nxt);
  assign seed_fold = 17'(seed_wide[15:0]) + 17'(seed_wide[19:16]);
  assign seed_sum  = seed_fold[15:0] + 16'(seed_fold[16]);

  // payload word add with end-around carry
  assign word_sum = 17'(running_sum_r) + 17'(stage_r.data_word);
  assign word_res = word_sum[15:0] + 16'(word_sum[16]);

  // next state of the held header fields and the sum
  always_comb begin
    running_sum_nxt     = running_sum_r;
    held_src_port_nxt   = held_src_port_r;
    held_dest_port_nxt  = held_dest_port_r;
    held_udp_length_nxt = held_udp_length_r;
    case (stage_r.action)
      udpcs_pkg::ACT_HEADER: begin
        held_src_port_nxt   = stage_r.src_port;
        held_dest_port_nxt  = stage_r.dns_mode ? udpcs_pkg::DNS_PORT : stage_r.dest_port;
        held_udp_length_nxt = stage_r.payload_len + udpcs_pkg::UDP_HDR_BYTES;
        running_sum_nxt     = seed_sum;
      end
      default: begin
        running_sum_nxt = word_res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r     <= '0;
      held_src_port_r   <= '0;
      held_dest_port_r  <= '0;
      held_udp_length_r <= '0;
    end else if (stage_fire) begin
      running_sum_r     <= running_sum_nxt;
      held_src_port_r   <= held_src_port_nxt;
      held_dest_port_r  <= held_dest_port_nxt;
      held_udp_length_r <= held_udp_length_nxt;
    end
  end

  // final request hands the four words to the output buffer
  assign hand_valid          = stage_valid_r && stage_r.last;
  assign hand_words.src_port = held_src_port_nxt;
  assign hand_words.dst_port = held_dest_port_nxt;
  assign hand_words.length   = held_udp_length_nxt;
  assign hand_words.checksum = ~running_sum_nxt;

  // a blocked final request must hold off new requests
  `UDPCS_ASSERT(a_stall_blocks_input, (stage_valid_r && !stage_fire) |-> !in_chan.ready, "input taken while stage is blocked")
  // state moves only when a staged request is consumed
  `UDPCS_ASSERT(a_sum_moves_on_fire, !$past(stage_fire) |-> $stable(running_sum_r), "sum changed without a consumed request")

endmodule

>>> hdl/udpcs_hdr_out.sv
// four-word header output buffer and serializer
`include "udp_header_checksum_builder_core_defines.svh"

module udpcs_hdr_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  hand_valid,
  input  udpcs_pkg::hdr_words_t hand_words,
  output logic                  hand_ready,
  udpcs_out_if.source           out_chan
);

  udpcs_pkg::hdr_words_t words_r;
  logic                  buf_valid_r, buf_valid_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  out_fire;
  logic                  load;
  logic                  at_end;

  assign out_fire   = out_chan.valid && out_chan.ready;
  assign at_end     = idx_r == udpcs_pkg::IDX_CHECKSUM;
  assign hand_ready = !buf_valid_r || (out_fire && at_end);
  assign load       = hand_valid && hand_ready;

  // word position and occupancy
  always_comb begin
    buf_valid_nxt = buf_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      buf_valid_nxt = 1'b1;
      idx_nxt       = udpcs_pkg::IDX_SRC_PORT;
    end else if (out_fire) begin
      buf_valid_nxt = !at_end;
      idx_nxt       = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= udpcs_pkg::IDX_SRC_PORT;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words_r <= hand_words;
    end
  end

  // word select
  always_comb begin
    case (idx_r)
      udpcs_pkg::IDX_SRC_PORT: out_chan.header_word = words_r.src_port;
      udpcs_pkg::IDX_DST_PORT: out_chan.header_word = words_r.dst_port;
      udpcs_pkg::IDX_LENGTH:   out_chan.header_word = words_r.length;
      default:                 out_chan.header_word = words_r.checksum;
    endcase
  end

  assign out_chan.valid      = buf_valid_r;
  assign out_chan.word_index = idx_r;
  assign out_chan.last_word  = at_end;

  // a new header set only replaces a buffer that is free or just drained
  `UDPCS_ASSERT(a_load_when_free, (load && buf_valid_r) |-> (out_fire && at_end), "buffer overwritten while busy")
  // a taken word that is not the checksum is followed by the next word
  `UDPCS_ASSERT(a_word_advance, (out_fire && !at_end) |=> (buf_valid_r && idx_r == $past(idx_r) + 2'd1), "header word skipped")
  // reset empties the buffer
  `UDPCS_ASSERT_RST(a_reset_empty, !rst_n |=> !buf_valid_r, "buffer valid after reset")

endmodule

>>> sim/udp_header_checker.sv
// checker for the udp header builder: predicts the header words and compares them
module udp_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  udpcs_in_if         in_mon,
  udpcs_out_if        out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        run_done,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  idx;
    logic        last_word;
  } hdr_word_t;

  // header words still owed by the block, oldest first
  hdr_word_t   hdr_words_due[$];

  // shadow of the registers and of the running packet
  logic [31:0] own_ip;
  logic [31:0] gw_ip;
  logic [15:0] csum_acc;
  logic [15:0] hdr_src;
  logic [15:0] hdr_dst;
  logic [15:0] hdr_len;
  bit          leftover_checked;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // fold one request into the running checksum, queue the header on last
  task automatic absorb_request(input udpcs_pkg::in_item_t req);
    logic [31:0] dst_ip;
    logic [15:0] sum;
    if (req.action == udpcs_pkg::ACT_HEADER) begin
      dst_ip  = req.dns_mode ? gw_ip : req.dest_ip;
      hdr_src = req.src_port;
      hdr_dst = req.dns_mode ? udpcs_pkg::DNS_PORT : req.dest_port;
      hdr_len = req.payload_len + udpcs_pkg::UDP_HDR_BYTES;
      // pseudo-header, then the header itself with a zero checksum
      sum = own_ip[31:16];
      sum = ones_add(sum, own_ip[15:0]);
      sum = ones_add(sum, dst_ip[31:16]);
      sum = ones_add(sum, dst_ip[15:0]);
      sum = ones_add(sum, udpcs_pkg::UDP_PROTOCOL);
      sum = ones_add(sum, hdr_len);
      sum = ones_add(sum, hdr_src);
      sum = ones_add(sum, hdr_dst);
      sum = ones_add(sum, hdr_len);
      csum_acc = sum;
    end else begin
      csum_acc = ones_add(csum_acc, req.data_word);
    end
    if (req.last) begin
      hdr_words_due.push_back('{word: hdr_src, idx: udpcs_pkg::IDX_SRC_PORT,
                                last_word: 1'b0});
      hdr_words_due.push_back('{word: hdr_dst, idx: udpcs_pkg::IDX_DST_PORT,
                                last_word: 1'b0});
      hdr_words_due.push_back('{word: hdr_len, idx: udpcs_pkg::IDX_LENGTH,
                                last_word: 1'b0});
      hdr_words_due.push_back('{word: ~csum_acc, idx: udpcs_pkg::IDX_CHECKSUM,
                                last_word: 1'b1});
    end
  endtask

  // compare one delivered header word with the oldest one owed
  task automatic check_header_word();
    hdr_word_t want;
    if (hdr_words_due.size() == 0) begin
      report_mismatch("unexpected header word", 32'(out_mon.header_word), 32'd0);
    end else begin
      want = hdr_words_due.pop_front();
      if (out_mon.header_word !== want.word)
        report_mismatch("header_word", 32'(out_mon.header_word), 32'(want.word));
      if (out_mon.word_index !== want.idx)
        report_mismatch("word_index", 32'(out_mon.word_index), 32'(want.idx));
      if (out_mon.last_word !== want.last_word)
        report_mismatch("last_word", 32'(out_mon.last_word), 32'(want.last_word));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      own_ip     = '0;
      gw_ip      = '0;
      csum_acc   = '0;
      hdr_src    = '0;
      hdr_dst    = '0;
      hdr_len    = '0;
      fail_count = 0;
      hdr_words_due.delete();
      pending <= 0;
    end else begin
      // register writes and read-back
      if (psel && penable && pready && pwrite) begin
        case (paddr[2])
          udpcs_pkg::REG_LOCAL_IP:   own_ip = pwdata;
          udpcs_pkg::REG_GATEWAY_IP: gw_ip  = pwdata;
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite) begin
        case (paddr[2])
          udpcs_pkg::REG_LOCAL_IP:
            if (prdata !== own_ip) report_mismatch("local_ip read", prdata, own_ip);
          udpcs_pkg::REG_GATEWAY_IP:
            if (prdata !== gw_ip) report_mismatch("gateway_ip read", prdata, gw_ip);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready)
        check_header_word();
      if (in_mon.valid && in_mon.ready)
        absorb_request({in_mon.action, in_mon.dest_ip, in_mon.src_port, in_mon.dest_port,
                        in_mon.dns_mode, in_mon.payload_len, in_mon.data_word,
                        in_mon.last});
      pending <= hdr_words_due.size();
    end
    // anything still owed at the end of the run
    if (run_done && !leftover_checked) begin
      leftover_checked = 1'b1;
      if (hdr_words_due.size() != 0)
        report_mismatch("header words never delivered", 32'(hdr_words_due.size()), 32'd0);
    end
  end

endmodule

>>> sim/testbench.sv
// top of the udp header builder testbench: clock, reset, requests, register traffic, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 48;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        run_done;
  int          pending;
  int          fail_count;
  int          cycle_count = 0;
  int          items_sent;
  int          hold_req;
  int          hold_left;
  bit          hold_taken;
  bit          tx_gaps;
  bit          rx_gaps;

  udpcs_in_if  in_chan ();
  udpcs_out_if out_chan ();

  udp_header_checksum_builder_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  udp_header_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .run_done   (run_done),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0 && !hold_taken) begin
        hold_left  = hold_req;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= !(rx_gaps && $urandom_range(0, 99) < 28);
      end
    end
  end

  function automatic udpcs_pkg::in_item_t header_req(input logic [15:0] sport,
                                                     input logic [15:0] dport,
                                                     input logic [31:0] dip,
                                                     input logic [15:0] plen,
                                                     input logic dns, input logic last);
    udpcs_pkg::in_item_t it;
    it.action      = udpcs_pkg::ACT_HEADER;
    it.dest_ip     = dip;
    it.src_port    = sport;
    it.dest_port   = dport;
    it.dns_mode    = dns;
    it.payload_len = plen;
    it.data_word   = 16'($urandom_range(0, 65535));
    it.last        = last;
    return it;
  endfunction

  // payload request, unused fields filled with noise
  function automatic udpcs_pkg::in_item_t payload_req(input logic [15:0] word,
                                                      input logic last);
    udpcs_pkg::in_item_t it;
    it.action      = udpcs_pkg::ACT_PAYLOAD;
    it.dest_ip     = $urandom;
    it.src_port    = 16'($urandom_range(0, 65535));
    it.dest_port   = 16'($urandom_range(0, 65535));
    it.dns_mode    = 1'($urandom_range(0, 1));
    it.payload_len = 16'($urandom_range(0, 65535));
    it.data_word   = word;
    it.last        = last;
    return it;
  endfunction

  function automatic udpcs_pkg::in_item_t random_header(input logic last);
    logic [15:0] plen;
    if ($urandom_range(0, 7) == 0) plen = 16'($urandom_range(0, 65535));
    else plen = 16'($urandom_range(0, 32763) * 2);
    return header_req(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      $urandom, plen, $urandom_range(0, 3) == 0, last);
  endfunction

  // offer one request and hold it until taken
  task automatic push_request(input udpcs_pkg::in_item_t it);
    while (tx_gaps && $urandom_range(0, 99) < 28) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    {in_chan.action, in_chan.dest_ip, in_chan.src_port, in_chan.dest_port, in_chan.dns_mode,
     in_chan.payload_len, in_chan.data_word, in_chan.last} <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop sending and let every owed header word come out
  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic addr_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {addr_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic addr_sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {addr_sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_addresses(input logic [31:0] own, input logic [31:0] gw);
    reg_write(udpcs_pkg::REG_LOCAL_IP, own);
    reg_write(udpcs_pkg::REG_GATEWAY_IP, gw);
    reg_read(udpcs_pkg::REG_LOCAL_IP);
    reg_read(udpcs_pkg::REG_GATEWAY_IP);
  endtask

  // one random packet, or now and then a stray or broken sequence
  task automatic random_packet();
    int roll;
    int n_words;
    roll = int'($urandom_range(0, 99));
    if (roll < 8) begin
      // payload word with no header in front of it
      push_request(payload_req(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
    end else if (roll < 14) begin
      // packet cut short, the next header reseeds
      push_request(random_header(1'b0));
      n_words = int'($urandom_range(0, 2));
      repeat (n_words) push_request(payload_req(16'($urandom_range(0, 65535)), 1'b0));
    end else begin
      n_words = int'($urandom_range(0, 6));
      push_request(random_header(n_words == 0));
      for (int k = 1; k <= n_words; k++)
        push_request(payload_req(16'($urandom_range(0, 65535)), k == n_words));
    end
    if ($urandom_range(0, 11) == 0) wait_for_results();
  endtask

  initial begin
    int base_items;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    run_done    = 1'b0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    hold_req    = 0;
    items_sent  = 0;
    in_chan.valid = 1'b0;
    {in_chan.action, in_chan.dest_ip, in_chan.src_port, in_chan.dest_port, in_chan.dns_mode,
     in_chan.payload_len, in_chan.data_word, in_chan.last} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // payload before any header: held ports, length and sum are still zero
    push_request(payload_req(16'h0000, 1'b1));
    push_request(payload_req(16'h1234, 1'b0));
    push_request(payload_req(16'hFFFF, 1'b1));
    // addresses at reset value: ports chosen so the sum is all ones, checksum zero
    push_request(header_req(16'hFFDE, 16'h0000, 32'h0, 16'h0000, 1'b0, 1'b1));
    push_request(header_req(16'h0000, 16'h0000, 32'h0, 16'h0000, 1'b0, 1'b1));
    wait_for_results();

    set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // dns mode with the largest even payload
    push_request(header_req(16'hFFFF, 16'h1234, 32'h0, 16'd65526, 1'b1, 1'b0));
    push_request(payload_req(16'hFFFF, 1'b0));
    push_request(payload_req(16'h0000, 1'b1));
    // length wraps past 16 bits
    push_request(header_req(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1));
    push_request(header_req(16'h8000, 16'h0001, 32'h8000_0001, 16'hFFF8, 1'b0, 1'b1));
    // odd length taken as given
    push_request(header_req(16'h0007, 16'h0035, 32'h0A00_0001, 16'h0001, 1'b0, 1'b0));
    push_request(payload_req(16'h00AB, 1'b1));
    // header in the middle of a packet drops the open one
    push_request(header_req(16'h1111, 16'h2222, 32'h0102_0304, 16'd4, 1'b0, 1'b0));
    push_request(payload_req(16'h5555, 1'b0));
    push_request(header_req(16'h3333, 16'h4444, 32'h0506_0708, 16'd2, 1'b1, 1'b0));
    push_request(payload_req(16'hAAAA, 1'b1));
    // payload after the last word keeps adding to the old sum
    push_request(payload_req(16'h8000, 1'b1));
    wait_for_results();

    set_addresses(32'h0000_0000, 32'hC0A8_0001);
    push_request(header_req(16'hC000, 16'h0000, 32'h0, 16'd0, 1'b1, 1'b1));
    push_request(header_req(16'h0400, 16'h0050, 32'h7F00_0001, 16'd16, 1'b0, 1'b1));
    wait_for_results();

    // random traffic in phases, addresses changed while idle
    base_items = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      set_addresses($urandom, (phase == 3) ? 32'h0 : $urandom);
      tx_gaps = (phase != 1);
      rx_gaps = (phase != 1);
      if (phase == 2) begin
        // result side holds off while final requests keep coming
        tx_gaps  = 1'b0;
        hold_req = 80;
        repeat (10) push_request(random_header(1'b1));
        tx_gaps  = 1'b1;
      end
      while (items_sent < base_items + (phase + 1) * ITEMS_PER_PHASE) random_packet();
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
